// ===== src/variable_record_stack_core_assert.svh =====
// Assertion macros for the RTL; only vrs_back includes them.
`ifndef VARIABLE_RECORD_STACK_CORE_ASSERT_SVH
`define VARIABLE_RECORD_STACK_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define VRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/vrs_pkg.sv =====
`default_nettype none
package vrs_pkg;
    localparam int LEN_W = 7;
    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 12'd4095;

    localparam logic [2:0] K_PUSH  = 3'd0;
    localparam logic [2:0] K_POP   = 3'd1;
    localparam logic [2:0] K_DROP  = 3'd2;
    localparam logic [2:0] K_CLEAR = 3'd3;
    localparam logic [2:0] K_COPY  = 3'd4;
    localparam logic [2:0] K_SWAP  = 3'd5;

    typedef struct packed {
        logic             supported;
        logic [2:0]       kind;
        logic [7:0]       data_byte;
        logic             byte_present;
        logic             last_byte;
        logic [LEN_W-1:0] max_length;
        logic [10:0]      pick_index;
    } t_cmd;

    typedef struct packed {
        logic             status;
        logic [7:0]       out_byte;
        logic             out_byte_valid;
        logic             last;
        logic [LEN_W-1:0] record_length;
        logic [CNT_W-1:0] record_count;
    } t_res;
endpackage
`default_nettype wire

// ===== src/vrs_front.sv =====
`default_nettype none
module vrs_front
    import vrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_last_byte,
    input  wire logic [6:0]  i_max_length,
    input  wire logic [10:0] i_pick_index,
    output logic             o_q_valid,
    output t_cmd             o_q_cmd,
    input  wire logic        i_q_pop
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_cmd       w_cmd;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;

    always_comb begin
        w_cmd.supported    = (i_kind <= K_SWAP);
        w_cmd.kind         = i_kind;
        w_cmd.data_byte    = i_data_byte;
        w_cmd.byte_present = i_byte_present;
        w_cmd.last_byte    = i_last_byte;
        w_cmd.max_length   = i_max_length;
        w_cmd.pick_index   = i_pick_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== src/vrs_back.sv =====
`default_nettype none
`include "variable_record_stack_core_assert.svh"
module vrs_back
    import vrs_pkg::*;
#(
    parameter int BUFFER_BYTES     = 4096,
    parameter int HEADER_BYTES     = 2,
    parameter int MAX_RECORD_BYTES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_q_pop,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);
    localparam int OW  = $clog2(BUFFER_BYTES + 1);
    localparam int OW1 = OW + 1;
    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int CW  = $clog2(2 * (MAX_RECORD_BYTES + HEADER_BYTES) + 1);
    localparam int KW  = $clog2(HEADER_BYTES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LEN   = 4'd1;
    localparam logic [3:0] S_CPRD  = 4'd2;
    localparam logic [3:0] S_CPWR  = 4'd3;
    localparam logic [3:0] S_HDR   = 4'd4;
    localparam logic [3:0] S_POPRD = 4'd5;
    localparam logic [3:0] S_POPWT = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;

    localparam logic [2:0] P_LEN_A  = 3'd0;
    localparam logic [2:0] P_LEN_B  = 3'd1;
    localparam logic [2:0] P_CPY_A  = 3'd2;
    localparam logic [2:0] P_CPY_B  = 3'd3;
    localparam logic [2:0] P_CPY_BK = 3'd4;

    localparam logic [OW-1:0]    HB   = OW'(HEADER_BYTES);
    localparam logic [OW1-1:0]   BUF1 = OW1'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_RECORD_BYTES);

    logic [7:0]       r_mem [BUFFER_BYTES];
    logic [7:0]       r_rd;
    logic [3:0]       r_st, n_st;
    logic [OW-1:0]    r_top, n_top;
    logic [CNT_W-1:0] r_held, n_held;
    logic [LEN_W-1:0] r_pend, n_pend;
    logic             r_povf, n_povf;
    logic             r_ov, n_ov;
    t_res             r_res, n_res;
    logic [2:0]       r_op, n_op;
    logic [2:0]       r_phase, n_phase;
    logic [OW-1:0]    r_pos, n_pos;
    logic [10:0]      r_depth, n_depth;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_alen, n_alen;
    logic [LEN_W-1:0] r_maxlen, n_maxlen;
    logic [OW-1:0]    r_src, n_src;
    logic [OW-1:0]    r_dst, n_dst;
    logic [OW-1:0]    r_bst, n_bst;
    logic [CW-1:0]    r_bsz, n_bsz;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [KW-1:0]    r_k, n_k;
    logic             r_est, n_est;
    logic [LEN_W-1:0] r_elen, n_elen;

    logic             w_we, w_re, w_free, e_do;
    logic [OW-1:0]    w_wa, w_ra;
    logic [7:0]       w_wd;
    logic [LEN_W-1:0] w_rlen;
    t_res             e_res;
    t_cmd             c;
    logic [LEN_W-1:0] v_pl;
    logic             v_ovf;
    logic [OW-1:0]    v_pos;
    logic [CW-1:0]    v_asz, v_bsz;

    function automatic t_res mk(input logic st, input logic [7:0] b, input logic v,
                                input logic l, input logic [LEN_W-1:0] len);
        t_res r;
        r.status         = st;
        r.out_byte       = b;
        r.out_byte_valid = v;
        r.last           = l;
        r.record_length  = len;
        r.record_count   = '0;
        return r;
    endfunction

    assign w_free      = !r_ov || i_res_ready;
    assign w_rlen      = (r_rd > 8'(MAX_RECORD_BYTES)) ? MAXL : r_rd[LEN_W-1:0];
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    always_comb begin
        n_st = r_st; n_top = r_top; n_held = r_held; n_pend = r_pend; n_povf = r_povf;
        n_op = r_op; n_phase = r_phase; n_pos = r_pos; n_depth = r_depth;
        n_len = r_len; n_alen = r_alen; n_maxlen = r_maxlen; n_src = r_src;
        n_dst = r_dst; n_bst = r_bst; n_bsz = r_bsz; n_cnt = r_cnt; n_k = r_k;
        n_est = r_est; n_elen = r_elen;
        n_ov = r_ov && !i_res_ready;
        n_res = r_res;
        w_we = 1'b0; w_wa = '0; w_wd = '0; w_re = 1'b0; w_ra = '0;
        e_do = 1'b0; e_res = mk(1'b0, 8'h00, 1'b0, 1'b1, '0);
        o_q_pop = 1'b0;
        c = i_q_cmd;
        v_pl = r_pend; v_ovf = r_povf; v_pos = r_pos; v_asz = '0; v_bsz = '0;

        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid && w_free) begin
                    o_q_pop = 1'b1;
                    n_op    = c.kind;
                    if (c.kind != K_PUSH) begin
                        n_pend = '0;
                        n_povf = 1'b0;
                    end
                    if (!c.supported) begin
                        e_do = 1'b1; e_res = mk(1'b1, 8'h00, 1'b0, 1'b1, '0);
                    end else begin
                        unique case (c.kind)
                            K_PUSH: begin
                                if (c.byte_present) begin
                                    if (v_pl < MAXL &&
                                        ({1'b0, r_top} + OW1'(v_pl)) < BUF1) begin
                                        w_we = 1'b1;
                                        w_wa = r_top + OW'(v_pl);
                                        w_wd = c.data_byte;
                                        v_pl = v_pl + 1'b1;
                                    end else begin
                                        v_ovf = 1'b1;
                                    end
                                end
                                if (!c.last_byte) begin
                                    n_pend = v_pl; n_povf = v_ovf;
                                    e_do = 1'b1; e_res = mk(v_ovf, 8'h00, 1'b0, 1'b1, '0);
                                end else begin
                                    n_pend = '0; n_povf = 1'b0;
                                    if (v_ovf || r_held >= COUNT_LIMIT ||
                                        ({1'b0, r_top} + OW1'(v_pl) + OW1'(HEADER_BYTES))
                                            > BUF1) begin
                                        e_do = 1'b1; e_res = mk(1'b1, 8'h00, 1'b0, 1'b1, '0);
                                    end else begin
                                        n_len = v_pl;
                                        n_dst = r_top + OW'(v_pl);
                                        n_k   = '0;
                                        n_st  = S_HDR;
                                    end
                                end
                            end
                            K_POP, K_DROP, K_SWAP: begin
                                if (r_held == '0 || (c.kind == K_SWAP && r_held < 12'd2)) begin
                                    e_do = 1'b1; e_res = mk(1'b1, 8'h00, 1'b0, 1'b1, '0);
                                end else begin
                                    w_re = 1'b1; w_ra = r_top - HB;
                                    n_maxlen = c.max_length;
                                    n_phase = P_LEN_A;
                                    n_st = S_LEN;
                                end
                            end
                            K_CLEAR: begin
                                n_top = '0; n_held = '0;
                                e_do = 1'b1;
                            end
                            K_COPY: begin
                                if ({1'b0, c.pick_index} >= r_held) begin
                                    e_do = 1'b1; e_res = mk(1'b1, 8'h00, 1'b0, 1'b1, '0);
                                end else begin
                                    w_re = 1'b1; w_ra = r_top - HB;
                                    n_pos = r_top; n_depth = c.pick_index;
                                    n_st = S_LEN;
                                end
                            end
                            default: begin
                                e_do = 1'b1; e_res = mk(1'b1, 8'h00, 1'b0, 1'b1, '0);
                            end
                        endcase
                    end
                end
            end
            S_LEN: begin
                n_st = S_EMIT; n_est = 1'b0; n_elen = '0;
                unique case (r_op)
                    K_POP: begin
                        if (r_maxlen < w_rlen) begin
                            n_est = 1'b1; n_elen = w_rlen;
                        end else begin
                            v_pos  = r_top - HB - OW'(w_rlen);
                            n_top  = v_pos;
                            n_held = r_held - 1'b1;
                            if (w_rlen != '0) begin
                                n_src = v_pos; n_cnt = CW'(w_rlen); n_len = w_rlen;
                                n_st = S_POPRD;
                            end
                        end
                    end
                    K_DROP: begin
                        n_top  = r_top - OW'(w_rlen) - HB;
                        n_held = r_held - 1'b1;
                    end
                    K_COPY: begin
                        if (r_depth != '0) begin
                            v_pos = r_pos - OW'(w_rlen) - HB;
                            n_pos = v_pos; n_depth = r_depth - 1'b1;
                            w_re = 1'b1; w_ra = v_pos - HB;
                            n_st = S_LEN;
                        end else if (r_held >= COUNT_LIMIT ||
                                     ({1'b0, r_top} + OW1'(w_rlen) + OW1'(HEADER_BYTES))
                                         > BUF1) begin
                            n_est = 1'b1;
                        end else begin
                            n_src = r_pos - HB - OW'(w_rlen);
                            n_dst = r_top; n_cnt = CW'(w_rlen); n_len = w_rlen;
                            n_k = '0;
                            n_st = (w_rlen == '0) ? S_HDR : S_CPRD;
                        end
                    end
                    K_SWAP: begin
                        if (r_phase == P_LEN_A) begin
                            v_pos = r_top - OW'(w_rlen) - HB;
                            n_alen = w_rlen; n_pos = v_pos;
                            w_re = 1'b1; w_ra = v_pos - HB;
                            n_phase = P_LEN_B; n_st = S_LEN;
                        end else begin
                            v_asz = CW'(r_alen) + CW'(HEADER_BYTES);
                            v_bsz = CW'(w_rlen) + CW'(HEADER_BYTES);
                            if ((BUF1 - {1'b0, r_top}) < (OW1'(v_asz) + OW1'(v_bsz)) ||
                                r_pos < OW'(v_bsz)) begin
                                n_est = 1'b1;
                            end else begin
                                n_bst = r_pos - OW'(v_bsz); n_bsz = v_bsz;
                                n_src = r_pos; n_dst = r_top; n_cnt = v_asz;
                                n_phase = P_CPY_A; n_st = S_CPRD;
                            end
                        end
                    end
                    default: n_est = 1'b1;
                endcase
            end
            S_CPRD: begin
                w_re = 1'b1; w_ra = r_src;
                n_st = S_CPWR;
            end
            S_CPWR: begin
                w_we = 1'b1; w_wa = r_dst; w_wd = r_rd;
                n_src = r_src + 1'b1; n_dst = r_dst + 1'b1; n_cnt = r_cnt - 1'b1;
                n_st = S_CPRD;
                if (r_cnt == CW'(1)) begin
                    if (r_op == K_COPY) begin
                        n_k = '0; n_st = S_HDR;
                    end else if (r_phase == P_CPY_A) begin
                        n_src = r_bst; n_cnt = r_bsz; n_phase = P_CPY_B;
                    end else if (r_phase == P_CPY_B) begin
                        n_src = r_top; n_dst = r_bst;
                        n_cnt = CW'(r_alen) + CW'(HEADER_BYTES) + r_bsz;
                        n_phase = P_CPY_BK;
                    end else begin
                        n_est = 1'b0; n_elen = '0; n_st = S_EMIT;
                    end
                end
            end
            S_HDR: begin
                w_we = 1'b1; w_wa = r_dst;
                w_wd = (r_k == '0) ? 8'(r_len) : 8'h00;
                n_dst = r_dst + 1'b1; n_k = r_k + 1'b1;
                if (r_k == KW'(HEADER_BYTES - 1)) begin
                    n_top = r_dst + 1'b1; n_held = r_held + 1'b1;
                    n_est = 1'b0; n_elen = '0; n_st = S_EMIT;
                end
            end
            S_POPRD: begin
                w_re = 1'b1; w_ra = r_src;
                n_st = S_POPWT;
            end
            S_POPWT: begin
                if (w_free) begin
                    e_do = 1'b1;
                    e_res = mk(1'b0, r_rd, 1'b1, r_cnt == CW'(1), r_len);
                    n_src = r_src + 1'b1; n_cnt = r_cnt - 1'b1;
                    n_st = (r_cnt == CW'(1)) ? S_IDLE : S_POPRD;
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    e_do = 1'b1; e_res = mk(r_est, 8'h00, 1'b0, 1'b1, r_elen);
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        if (e_do) begin
            n_ov = 1'b1;
            n_res = e_res;
            n_res.record_count = n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_top <= '0; r_held <= '0; r_pend <= '0;
            r_povf <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_top <= n_top; r_held <= n_held; r_pend <= n_pend;
            r_povf <= n_povf; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res; r_op <= n_op; r_phase <= n_phase; r_pos <= n_pos;
        r_depth <= n_depth; r_len <= n_len; r_alen <= n_alen; r_maxlen <= n_maxlen;
        r_src <= n_src; r_dst <= n_dst; r_bst <= n_bst; r_bsz <= n_bsz;
        r_cnt <= n_cnt; r_k <= n_k; r_est <= n_est; r_elen <= n_elen;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa[AW-1:0]] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_mem[w_ra[AW-1:0]];
        end
    end

    `VRS_ASSERT_NOW(a_top_range, 1'b1, r_top <= OW'(BUFFER_BYTES))
    `VRS_ASSERT_NOW(a_empty_top, r_held == '0, r_top == '0)
    `VRS_ASSERT_NOW(a_pop_idle, o_q_pop, r_st == S_IDLE && w_free)
    `VRS_ASSERT_NEXT(a_byte_out, r_st == S_POPWT && w_free, r_ov && r_res.out_byte_valid)
    `VRS_ASSERT_NOW(a_pend_max, 1'b1, r_pend <= MAXL)
endmodule
`default_nettype wire

// ===== src/variable_record_stack_core.sv =====
// Stack of variable-length byte records held in one byte memory.
// Input channel s_axis: one transaction per operation. tuser carries the
// kind and the byte-present flag, tlast marks the final byte of a pushed
// record, and tdata carries the byte, the pop length limit and the copy depth.
// Output channel m_axis: one transaction per result, with tlast on the final
// result of an operation and tuser flagging a record byte in tdata.
// A push byte is written when the execution unit takes it; the final byte of a
// record is followed by one write per length-word byte. A pop of a nonempty
// record reads its length word, then reads and emits its bytes one at a time.
// A copy steps over each record above the source, copies each byte with a
// read and a write, then writes the length word. A swap copies both records
// with their length words into free space and back, so both move twice. Drop
// reads one length word; clear only resets the stack. The memory has a single
// read and single write port. A two-entry queue sits ahead of the execution unit.
// After reset the stack is empty and no partial record is pending.
// When the receiver stalls, the output register holds its transaction and
// the execution unit waits; the input queue then fills and drops tready.
`default_nettype none
module variable_record_stack_core
    import vrs_pkg::*;
#(
    parameter int BUFFER_BYTES     = 4096,
    parameter int HEADER_BYTES     = 2,
    parameter int MAX_RECORD_BYTES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // data_byte, max_length, pick_index, zero pad
    input  wire logic [3:0]  s_axis_tuser,  // kind, byte_present
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // status, out_byte, record_length, record_count, zero pad
    output logic [0:0]       m_axis_tuser,  // out_byte_valid
    output logic             m_axis_tlast
);
    logic q_valid, q_pop;
    t_cmd q_cmd;
    t_res res;

    vrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_kind         (s_axis_tuser[2:0]),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_byte_present (s_axis_tuser[3]),
        .i_last_byte    (s_axis_tlast),
        .i_max_length   (s_axis_tdata[14:8]),
        .i_pick_index   (s_axis_tdata[25:15]),
        .o_q_valid      (q_valid),
        .o_q_cmd        (q_cmd),
        .i_q_pop        (q_pop)
    );

    vrs_back #(
        .BUFFER_BYTES     (BUFFER_BYTES),
        .HEADER_BYTES     (HEADER_BYTES),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {4'h0, res.record_count, res.record_length, res.out_byte, res.status};
    assign m_axis_tuser = res.out_byte_valid;
    assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

// ===== verif/tb_variable_record_stack_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_variable_record_stack_core;
    import vrs_pkg::*;

    localparam int STORE_BYTES = 4096;
    localparam int LEN_BYTES   = 2;
    localparam int REC_MAX     = 64;
    localparam int IDLE_LIMIT  = 20000;

    typedef struct packed {
        logic       status;
        logic [7:0] out_byte;
        logic       out_byte_valid;
        logic       last;
        logic [6:0] record_length;
        logic [11:0] record_count;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // data_byte, max_length, pick_index, zero pad
    logic [3:0]  s_axis_tuser = '0;  // kind, byte_present
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // status, out_byte, record_length, record_count, zero pad
    logic [0:0]  m_axis_tuser;  // out_byte_valid
    logic        m_axis_tlast;

    logic [7:0]  stack_bytes [STORE_BYTES];
    int unsigned model_top;
    int unsigned stack_depth;
    int unsigned open_len;
    bit          open_overflow;
    t_result     expected_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          stall_mode = 0;

    variable_record_stack_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned length_below(int unsigned end_pos);
        int unsigned v;
        if (end_pos < LEN_BYTES) return 0;
        v = 32'({stack_bytes[end_pos-1], stack_bytes[end_pos-2]});
        if (v > REC_MAX) v = REC_MAX;
        if (v > end_pos - LEN_BYTES) v = end_pos - LEN_BYTES;
        return v;
    endfunction

    function automatic void add_result(bit st, logic [7:0] b, bit bv, bit lst,
                                       int unsigned len);
        t_result r;
        r.status = st;
        r.out_byte = b;
        r.out_byte_valid = bv;
        r.last = lst;
        r.record_length = len[6:0];
        r.record_count = stack_depth[11:0];
        expected_results.push_back(r);
    endfunction

    function automatic void write_length(int unsigned pos, int unsigned len);
        stack_bytes[pos] = len[7:0];
        stack_bytes[pos+1] = len[15:8];
    endfunction

    function automatic void predict_operation(logic [2:0] kind, logic [7:0] data,
                                              bit present, bit lst,
                                              int unsigned max_len, int unsigned pick);
        int unsigned len, pos, src, a_size, b_end, b_size, b_start, room;
        bit fail;
        logic [7:0] tmp [2*(REC_MAX+LEN_BYTES)];
        if (kind != K_PUSH) begin
            open_len = 0;
            open_overflow = 0;
        end
        case (kind)
            K_PUSH: begin
                if (present) begin
                    if (open_len < REC_MAX && model_top + open_len < STORE_BYTES) begin
                        stack_bytes[model_top+open_len] = data;
                        open_len++;
                    end else begin
                        open_overflow = 1;
                    end
                end
                if (!lst) begin
                    add_result(open_overflow, 0, 0, 1, 0);
                end else begin
                    len = open_len;
                    fail = open_overflow || model_top + len + LEN_BYTES > STORE_BYTES
                           || stack_depth >= COUNT_LIMIT;
                    open_len = 0;
                    open_overflow = 0;
                    if (!fail) begin
                        write_length(model_top + len, len);
                        model_top += len + LEN_BYTES;
                        stack_depth++;
                    end
                    add_result(fail, 0, 0, 1, 0);
                end
            end
            K_POP: begin
                if (stack_depth == 0) begin
                    add_result(1, 0, 0, 1, 0);
                end else begin
                    len = length_below(model_top);
                    if (max_len < len) begin
                        add_result(1, 0, 0, 1, len);
                    end else begin
                        src = model_top - LEN_BYTES - len;
                        model_top = src;
                        stack_depth--;
                        if (len == 0) add_result(0, 0, 0, 1, 0);
                        for (int i = 0; i < len; i++)
                            add_result(0, stack_bytes[src+i], 1, i + 1 == len, len);
                    end
                end
            end
            K_DROP: begin
                if (stack_depth == 0) begin
                    add_result(1, 0, 0, 1, 0);
                end else begin
                    model_top -= length_below(model_top) + LEN_BYTES;
                    stack_depth--;
                    add_result(0, 0, 0, 1, 0);
                end
            end
            K_CLEAR: begin
                model_top = 0;
                stack_depth = 0;
                add_result(0, 0, 0, 1, 0);
            end
            K_COPY: begin
                if (pick >= stack_depth) begin
                    add_result(1, 0, 0, 1, 0);
                end else begin
                    pos = model_top;
                    for (int i = 0; i < pick; i++) begin
                        len = length_below(pos) + LEN_BYTES;
                        pos = pos < len ? 0 : pos - len;
                    end
                    len = length_below(pos);
                    src = pos - LEN_BYTES - len;
                    if (model_top + len + LEN_BYTES > STORE_BYTES
                        || stack_depth >= COUNT_LIMIT) begin
                        add_result(1, 0, 0, 1, 0);
                    end else begin
                        for (int i = 0; i < len; i++)
                            stack_bytes[model_top+i] = stack_bytes[src+i];
                        write_length(model_top + len, len);
                        model_top += len + LEN_BYTES;
                        stack_depth++;
                        add_result(0, 0, 0, 1, 0);
                    end
                end
            end
            K_SWAP: begin
                if (stack_depth < 2) begin
                    add_result(1, 0, 0, 1, 0);
                end else begin
                    a_size = length_below(model_top) + LEN_BYTES;
                    b_end = model_top - a_size;
                    b_size = length_below(b_end) + LEN_BYTES;
                    room = model_top > STORE_BYTES ? 0 : STORE_BYTES - model_top;
                    if (room < a_size + b_size || b_end < b_size) begin
                        add_result(1, 0, 0, 1, 0);
                    end else begin
                        b_start = b_end - b_size;
                        for (int i = 0; i < a_size; i++) tmp[i] = stack_bytes[b_end+i];
                        for (int i = 0; i < b_size; i++)
                            tmp[a_size+i] = stack_bytes[b_start+i];
                        for (int i = 0; i < a_size + b_size; i++)
                            stack_bytes[b_start+i] = tmp[i];
                        add_result(0, 0, 0, 1, 0);
                    end
                end
            end
            default: add_result(1, 0, 0, 1, 0);
        endcase
    endfunction

    task automatic send_operation(logic [2:0] kind, logic [7:0] data = 0, bit present = 0,
                                  bit lst = 0, logic [6:0] max_len = 0,
                                  logic [10:0] pick = 0);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {present, kind};
        s_axis_tdata <= {6'd0, pick, max_len, data};
        s_axis_tlast <= lst;
        predict_operation(kind, data, present, lst, max_len, pick);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic push_record(int unsigned len);
        if (len == 0) send_operation(K_PUSH, 0, 0, 1);
        for (int i = 0; i < len; i++)
            send_operation(K_PUSH, 8'($urandom_range(0, 255)), 1, i + 1 == len);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_operation(K_POP, 0, 0, 0, 64);
        send_operation(K_DROP);
        send_operation(K_SWAP);
        send_operation(K_COPY, 0, 0, 0, 0, 0);
        send_operation(3'd6);
        send_operation(3'd7, 8'hFF, 1, 1, 7'h7F, 11'h7FF);
        push_record(0);
        send_operation(K_PUSH, 8'h00, 1, 0);
        send_operation(K_PUSH, 8'hFF, 1, 1);
        send_operation(K_PUSH, 8'hA5, 1, 0);
        send_operation(K_PUSH, 8'h5A, 0, 0);
        send_operation(K_DROP);
        send_operation(K_COPY, 0, 0, 0, 0, 11'd1);
        send_operation(K_COPY, 0, 0, 0, 0, 11'd0);
        send_operation(K_COPY, 0, 0, 0, 0, 11'd3);
        send_operation(K_COPY, 0, 0, 0, 0, 11'h7FF);
        send_operation(K_SWAP);
        send_operation(K_POP, 0, 0, 0, 7'd1);
        send_operation(K_POP, 0, 0, 0, 7'd2);
        send_operation(K_POP, 0, 0, 0, 7'h7F);
        send_operation(K_POP, 0, 0, 0, 7'd0);
        send_operation(K_CLEAR);
        wait_drained();
    endtask

    task automatic test_long_records();
        push_record(REC_MAX);
        for (int i = 0; i < REC_MAX + 1; i++)
            send_operation(K_PUSH, i[7:0], 1, i == REC_MAX);
        push_record(3);
        send_operation(K_SWAP);
        send_operation(K_POP, 0, 0, 0, 7'd63);
        send_operation(K_POP, 0, 0, 0, 7'd64);
        send_operation(K_POP, 0, 0, 0, 7'd64);
        wait_drained();
    endtask

    task automatic test_full_store();
        send_operation(K_CLEAR);
        push_record(REC_MAX);
        for (int i = 0; i < 64; i++) send_operation(K_COPY, 0, 0, 0, 0, 11'(i % 2));
        send_operation(K_SWAP);
        push_record(4);
        send_operation(K_POP, 0, 0, 0, 7'd64);
        send_operation(K_SWAP);
        push_record(2);
        send_operation(K_CLEAR);
        wait_drained();
    endtask

    task automatic test_random();
        int unsigned sel;
        for (int n = 0; n < 10; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                push_record($urandom_range(0, 3) == 0 ? $urandom_range(0, 64)
                                                      : $urandom_range(0, 6));
            end else if (sel < 55) begin
                send_operation(K_POP, 0, 0, 0, $urandom_range(0, 3) == 0
                               ? 7'($urandom_range(0, 127)) : 7'd64);
            end else if (sel < 65) begin
                send_operation(K_COPY, 0, 0, 0, 0, $urandom_range(0, 3) == 0
                               ? 11'($urandom_range(0, 2047))
                               : 11'($urandom_range(0, stack_depth)));
            end else if (sel < 75) begin
                send_operation(K_SWAP);
            end else if (sel < 85) begin
                send_operation(K_DROP);
            end else if (sel < 88) begin
                send_operation(K_CLEAR);
            end else if (sel < 92) begin
                send_operation(3'($urandom_range(6, 7)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_operation(K_PUSH, 8'($urandom_range(0, 255)), 1, 0);
            end
        end
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (stall_mode == 0) begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0) stall_mode = 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 99) == 0) stall_mode = 0;
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_variable_record_stack_core: errors");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tdata[0];
                got.out_byte = m_axis_tdata[8:1];
                got.out_byte_valid = m_axis_tuser[0];
                got.last = m_axis_tlast;
                got.record_length = m_axis_tdata[15:9];
                got.record_count = m_axis_tdata[27:16];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %h actual %h", $time, want, got);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        model_top = 0;
        stack_depth = 0;
        open_len = 0;
        open_overflow = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_long_records();
        test_full_store();
        test_random();
        if (error_count == 0)
            $display("tb_variable_record_stack_core: clean");
        else
            $display("tb_variable_record_stack_core: errors");
        $finish;
    end
endmodule
`default_nettype wire
